>>> rtl/mtsed_pkg.sv
`default_nettype none

package mtsed_pkg;

	// Longest entity name that is kept; longer names decode as unknown.
	localparam int ENTITY_MAX = 5;
	localparam int LEN_W = $clog2(ENTITY_MAX + 2);
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(ENTITY_MAX + 1);

	localparam logic [7:0] CH_LT    = 8'h3C;	// '<'
	localparam logic [7:0] CH_GT    = 8'h3E;	// '>'
	localparam logic [7:0] CH_AMP   = 8'h26;	// '&'
	localparam logic [7:0] CH_SEMI  = 8'h3B;	// ';'
	localparam logic [7:0] CH_DQUOT = 8'h22;	// '"'

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_TAG    = 2'd1,
		MODE_ENTITY = 2'd2
	} mode_t;

	typedef logic [ENTITY_MAX-1:0][7:0] ent_name_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       terminator;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       done_res;
		logic       unterminated;
	} result_t;

	// Known names: lt, gt, amp, quote. Anything else gives a zero byte.
	function automatic logic [7:0] decode_entity(ent_name_t c, logic [LEN_W-1:0] len);
		logic [7:0] r;
		r = 8'h00;
		if (len == LEN_W'(2) && c[0] == "l" && c[1] == "t")
			r = CH_LT;
		else if (len == LEN_W'(2) && c[0] == "g" && c[1] == "t")
			r = CH_GT;
		else if (len == LEN_W'(3) && c[0] == "a" && c[1] == "m" && c[2] == "p")
			r = CH_AMP;
		else if (len == LEN_W'(5) && c[0] == "q" && c[1] == "u" && c[2] == "o"
				&& c[3] == "t" && c[4] == "e")
			r = CH_DQUOT;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/markup_tag_strip_entity_decode.sv
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] text_byte, tlast terminator
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata[7:0] out_char, tlast done_res,
//                                               tuser unterminated
//
// One byte per cycle sustained while m_axis_tready stays high; each transaction
// passes through the input register and then the result register to m_axis.
// Scan state (mode, entity length, entity name bytes) updates when the input
// register hands its byte on; the name bytes carry no reset.
// Reset is asynchronous and active low and clears all valid and mode state.
// A stalled m_axis holds the result and also the staged byte, even one that
// yields nothing; with the input and result registers both full,
// s_axis_tready follows m_axis_tready in the same cycle.
module markup_tag_strip_entity_decode (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,	// [7:0] text_byte
	input  wire logic       s_axis_tlast,	// terminator (end of string)
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,	// [7:0] out_char
	output logic            m_axis_tlast,	// done_res
	output logic            m_axis_tuser	// [0] unterminated
);

	mtsed_pkg::item_t   in_item;
	mtsed_pkg::item_t   item_s1;
	logic               valid_s1;
	logic               advance;
	logic               out_free;
	logic               res_valid;
	mtsed_pkg::result_t res;
	mtsed_pkg::result_t res_q;

	assign in_item.text_byte  = s_axis_tdata;
	assign in_item.terminator = s_axis_tlast;

	// The staged byte moves on only when the result register can take
	// whatever it produces; bytes that yield nothing move on the same way.
	assign advance = valid_s1 && out_free;

	mtsed_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mtsed_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mtsed_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	assign m_axis_tdata = res_q.out_char;
	assign m_axis_tlast = res_q.done_res;
	assign m_axis_tuser = res_q.unterminated;

endmodule

`default_nettype wire

>>> rtl/mtsed_in_stage.sv
`default_nettype none

module mtsed_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire mtsed_pkg::item_t in_item,
	input  wire logic             advance,
	output logic                  valid_s1,
	output mtsed_pkg::item_t      item_s1
);

	// Stage is free when empty or when its item leaves this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mtsed_scan.sv
`default_nettype none

module mtsed_scan (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire mtsed_pkg::item_t item,
	output logic                  res_valid,
	output mtsed_pkg::result_t    res
);

	mtsed_pkg::mode_t                mode_q, mode_n;
	logic [mtsed_pkg::LEN_W-1:0]     len_q, len_n;
	mtsed_pkg::ent_name_t            name_q;
	logic                            wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mtsed_pkg::MODE_PLAIN;
			len_q  <= '0;
		end else if (go) begin
			mode_q <= mode_n;
			len_q  <= len_n;
		end
	end

	// Name bytes: only entries below len_q are ever read.
	always_ff @(posedge clk) begin
		for (int i = 0; i < mtsed_pkg::ENTITY_MAX; i++) begin
			if (go && wr_en && len_q == mtsed_pkg::LEN_W'(i)) begin
				name_q[i] <= item.text_byte;
			end
		end
	end

	always_comb begin
		mode_n    = mode_q;
		len_n     = len_q;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		if (item.terminator) begin
			res_valid        = 1'b1;
			res.done_res     = 1'b1;
			res.unterminated = (mode_q == mtsed_pkg::MODE_TAG) ||
					(mode_q == mtsed_pkg::MODE_ENTITY);
			mode_n           = mtsed_pkg::MODE_PLAIN;
			len_n            = '0;
		end else begin
			unique case (mode_q)
				mtsed_pkg::MODE_TAG: begin
					if (item.text_byte == mtsed_pkg::CH_GT)
						mode_n = mtsed_pkg::MODE_PLAIN;
				end
				mtsed_pkg::MODE_ENTITY: begin
					if (item.text_byte == mtsed_pkg::CH_SEMI) begin
						res_valid    = 1'b1;
						res.out_char = mtsed_pkg::decode_entity(name_q, len_q);
						mode_n       = mtsed_pkg::MODE_PLAIN;
						len_n        = '0;
					end else begin
						wr_en = len_q < mtsed_pkg::LEN_W'(mtsed_pkg::ENTITY_MAX);
						if (len_q != mtsed_pkg::LEN_SAT)
							len_n = len_q + 1'b1;
					end
				end
				default: begin
					// plain text; the unused code behaves the same
					mode_n = mtsed_pkg::MODE_PLAIN;
					if (item.text_byte == mtsed_pkg::CH_LT) begin
						mode_n = mtsed_pkg::MODE_TAG;
					end else if (item.text_byte == mtsed_pkg::CH_AMP) begin
						mode_n = mtsed_pkg::MODE_ENTITY;
						len_n  = '0;
					end else begin
						res_valid    = 1'b1;
						res.out_char = item.text_byte;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/mtsed_out_reg.sv
`default_nettype none

module mtsed_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire mtsed_pkg::result_t res,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mtsed_pkg::result_t      res_q
);

	// Free when empty or drained this cycle.
	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mtsed_checker.sv
`default_nettype none

module mtsed_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// Unterminated flag only rides on the done transaction.
	a_unterm_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("unterminated set on a non-done transaction");

	// Done transaction carries a zero byte.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00)
		else $error("done transaction with nonzero byte");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output changed");

	// Nothing is offered while in reset.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind markup_tag_strip_entity_decode mtsed_checker u_mtsed_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
